// ----- src/fmve_pkg.sv -----
package fmve_pkg;

    typedef struct packed {
        logic              op;
        logic signed [31:0] coeff_in;
        logic              matrix_end;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] coeff_out;
        logic               row_end;
        logic               done_res;
    } out_item_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] SGN_ZERO = 2'd0;
    localparam logic [1:0] SGN_NEG  = 2'd1;
    localparam logic [1:0] SGN_POS  = 2'd2;

    localparam logic [1:0] CFG_NUM_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ELIM_COLUMN   = 2'd1;
    localparam logic [1:0] CFG_ASSUME_NONNEG = 2'd2;

endpackage

// ----- src/fourier_motzkin_variable_elimination_top.sv -----
// channel  | valid  | ready | payload
// item in  | start  | busy  | in_item  (fmve_pkg::in_item_t)
// result   | strobe | none  | result   (fmve_pkg::out_item_t)
// config   | cfg_we | none  | cfg_index, cfg_data
// A load item passes through S_LOAD; matrix_end adds zero fill for a partial row and
// sign capture for each loaded row.
// A read that starts a new result row first searches row pairs: each pairing reads the
// pivots, then runs the remainder steps and the quotient divisions in the shared gcd unit,
// then scales each kept column through one 32x32 multiplier; a copied row reads each
// kept column. Later reads in a row go through S_OUT. Reset is asynchronous and leaves
// the matrix store undefined; the receiver cannot stall, so a result shows for one cycle.
module fourier_motzkin_variable_elimination_top #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fmve_pkg::in_item_t  in_item,
    output logic                strobe,
    output fmve_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data
);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int RI = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RI + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_FILL, S_SIGN, S_SEEK, S_PIV, S_GCDW, S_COL, S_MUL, S_NEXT,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] num_cols_reg;
    logic [2:0] elim_reg;
    logic       nonneg_reg;

    logic signed [31:0] mem [2**AW];
    logic signed [31:0] rd_reg;
    logic [AW-1:0] addr;
    logic [1:0]  sign_reg [MAX_ROWS];
    logic [RW-1:0] rows_reg;
    logic [CW:0]   lcol_reg;
    logic [RW-1:0] neg_reg;
    logic [RW:0]   pos_reg;
    logic [1:0]    phase_reg;
    logic [CW:0]   ocol_reg;
    logic [63:0]   rbuf [MAX_COLS];
    logic [RW-1:0] sidx_reg;
    logic [CW:0]   k_reg, p_reg;
    logic          any_reg, combine_reg, mend_reg, fillz_reg;
    logic [1:0]    step_reg;
    logic signed [31:0] pi_reg, xi_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] diff;
    logic               gstart;
    logic               gbusy;
    logic signed [63:0] qa, qb;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    logic [CW:0] ncols, velim;
    always_comb
    begin
        ncols = (num_cols_reg < 4'd2) ? (CW+1)'(2)
              : (32'(num_cols_reg) > 32'(MAX_COLS)) ? (CW+1)'(MAX_COLS)
              : (CW+1)'(num_cols_reg);
        velim = (32'(elim_reg) >= 32'(ncols)) ? ncols - 1'b1 : (CW+1)'(elim_reg);
    end

    // The positive pivot is on the read port in the cycle that starts the gcd.
    fmve_gcd u_gcd (
        .clk(clk), .rst_n(rst_n), .start(gstart), .pa(pi_reg), .pb(rd_reg),
        .busy(gbusy), .qa(qa), .qb(qb)
    );
    assign gstart = (state_reg == S_PIV) && (step_reg == 2'd2);

    // Single shared multiplier: low 32 bits of a quotient times a coefficient.
    assign mul_a = (step_reg == 2'd3) ? qb[31:0] : qa[31:0];
    assign mul_b = rd_reg;
    logic signed [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign diff = prod_reg - mul_p;

    assign busy = (state_reg != S_IDLE);
    logic [RI-1:0] seek_row;
    assign seek_row = RI'(sidx_reg);

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[addr];
        if (state_reg == S_LOAD && !fillz_reg && rows_reg < RW'(MAX_ROWS))
            mem[addr] <= xi_reg;
        else if (state_reg == S_FILL && rows_reg < RW'(MAX_ROWS) && lcol_reg < (CW+1)'(MAX_COLS))
            mem[addr] <= '0;
    end

    always_comb
    begin
        addr = {RI'(rows_reg), CW'(lcol_reg)};
        case (state_reg)
            S_LOAD, S_FILL: addr = {RI'(rows_reg), CW'(lcol_reg)};
            S_SIGN:         addr = {seek_row, CW'(velim)};
            S_PIV:          addr = {(step_reg == 2'd0) ? RI'(neg_reg) : RI'(pos_reg - 1'b1),
                                    CW'(velim)};
            default:        addr = {(combine_reg && step_reg == 2'd1) ? RI'(pos_reg - 1'b1)
                                    : RI'(neg_reg), CW'(k_reg)};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_cols_reg <= 4'd8;
            elim_reg <= '0;
            nonneg_reg <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++)
                sign_reg[i] <= fmve_pkg::SGN_ZERO;
            rows_reg <= '0;
            lcol_reg <= '0;
            neg_reg <= '0;
            pos_reg <= '0;
            phase_reg <= 2'd0;
            ocol_reg <= '0;
            strobe <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            strobe <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    fmve_pkg::CFG_NUM_COLUMNS:   num_cols_reg <= cfg_data;
                    fmve_pkg::CFG_ELIM_COLUMN:   elim_reg <= cfg_data[2:0];
                    fmve_pkg::CFG_ASSUME_NONNEG: nonneg_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (in_item.op == fmve_pkg::OP_LOAD)
                        begin
                            mend_reg <= in_item.matrix_end;
                            xi_reg <= in_item.coeff_in;
                            fillz_reg <= 1'b0;
                            if (phase_reg != 2'd0)
                            begin
                                phase_reg <= 2'd0;
                                rows_reg <= '0;
                                lcol_reg <= '0;
                            end
                            else if (lcol_reg >= ncols)
                                lcol_reg <= ncols - 1'b1;
                            state_reg <= S_LOAD;
                        end
                        else if (phase_reg == 2'd0 || phase_reg == 2'd3)
                        begin
                            result <= '{coeff_out: '0, row_end: 1'b0, done_res: 1'b1};
                            strobe <= 1'b1;
                        end
                        else if (ocol_reg == '0)
                            state_reg <= S_SEEK;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_LOAD:
                begin
                    if (rows_reg < RW'(MAX_ROWS))
                    begin
                        if (lcol_reg + 1'b1 >= ncols)
                        begin
                            lcol_reg <= '0;
                            rows_reg <= rows_reg + 1'b1;
                        end
                        else
                            lcol_reg <= lcol_reg + 1'b1;
                    end
                    if (mend_reg)
                        state_reg <= S_FILL;
                    else
                        state_reg <= S_IDLE;
                end
                S_FILL:
                begin
                    if (lcol_reg == '0 || rows_reg >= RW'(MAX_ROWS))
                    begin
                        lcol_reg <= '0;
                        sidx_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_SIGN;
                    end
                    else if (lcol_reg >= (CW+1)'(MAX_COLS - 1))
                    begin
                        lcol_reg <= '0;
                        rows_reg <= rows_reg + 1'b1;
                    end
                    else
                        lcol_reg <= lcol_reg + 1'b1;
                end
                S_SIGN:
                begin
                    // Address is issued one cycle, data arrives the next.
                    if (step_reg == 2'd0)
                        step_reg <= 2'd1;
                    else
                    begin
                        if (sidx_reg < rows_reg)
                            sign_reg[seek_row] <= rd_reg[31] ? fmve_pkg::SGN_NEG
                                : (rd_reg != 0) ? fmve_pkg::SGN_POS : fmve_pkg::SGN_ZERO;
                        step_reg <= 2'd0;
                        if (sidx_reg + 1'b1 >= rows_reg || sidx_reg == RW'(MAX_ROWS - 1))
                        begin
                            phase_reg <= 2'd1;
                            neg_reg <= '0;
                            pos_reg <= '0;
                            ocol_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                            sidx_reg <= sidx_reg + 1'b1;
                    end
                end
                S_SEEK:
                begin
                    step_reg <= '0;
                    k_reg <= '0;
                    p_reg <= '0;
                    any_reg <= 1'b0;
                    if (phase_reg == 2'd1)
                    begin
                        if (neg_reg >= rows_reg)
                        begin
                            phase_reg <= 2'd2;
                            neg_reg <= '0;
                            pos_reg <= '0;
                        end
                        else if (sign_reg[RI'(neg_reg)] != fmve_pkg::SGN_NEG)
                        begin
                            neg_reg <= neg_reg + 1'b1;
                            pos_reg <= '0;
                        end
                        else if (pos_reg == '0)
                        begin
                            if (nonneg_reg)
                            begin
                                combine_reg <= 1'b0;
                                state_reg <= S_COL;
                            end
                            else
                                pos_reg <= (RW+1)'(1);
                        end
                        else if (pos_reg - 1'b1 >= (RW+1)'(rows_reg))
                        begin
                            neg_reg <= neg_reg + 1'b1;
                            pos_reg <= '0;
                        end
                        else if (sign_reg[RI'(pos_reg - 1'b1)] == fmve_pkg::SGN_POS)
                        begin
                            combine_reg <= 1'b1;
                            state_reg <= S_PIV;
                        end
                        else
                            pos_reg <= pos_reg + 1'b1;
                    end
                    else if (phase_reg == 2'd2)
                    begin
                        if (neg_reg >= rows_reg)
                        begin
                            phase_reg <= 2'd3;
                            result <= '{coeff_out: '0, row_end: 1'b0, done_res: 1'b1};
                            strobe <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (sign_reg[RI'(neg_reg)] == fmve_pkg::SGN_ZERO)
                        begin
                            combine_reg <= 1'b0;
                            state_reg <= S_COL;
                        end
                        else
                            neg_reg <= neg_reg + 1'b1;
                    end
                    else
                    begin
                        result <= '{coeff_out: '0, row_end: 1'b0, done_res: 1'b1};
                        strobe <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_PIV:
                begin
                    if (step_reg == 2'd1)
                        pi_reg <= rd_reg;
                    if (step_reg == 2'd1)
                        step_reg <= 2'd2;
                    else if (step_reg == 2'd0)
                        step_reg <= 2'd1;
                    else
                        state_reg <= S_GCDW;
                end
                S_GCDW:
                begin
                    step_reg <= '0;
                    if (!gbusy)
                        state_reg <= S_COL;
                end
                S_COL:
                begin
                    // Column loop: skip the eliminated column, read the coefficient(s).
                    if (k_reg >= ncols)
                        state_reg <= S_NEXT;
                    else if (k_reg == velim)
                        k_reg <= k_reg + 1'b1;
                    else
                    begin
                        step_reg <= 2'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // Step 0 issues the row i read, 3 scales it by the positive quotient,
                    // 1 issues the row j read, 2 subtracts its scaled value.
                    if (!combine_reg)
                    begin
                        if (step_reg == 2'd0)
                            step_reg <= 2'd1;
                        else
                        begin
                            rbuf[CW'(p_reg)] <= 64'(rd_reg);
                            any_reg <= any_reg | (rd_reg != 0);
                            p_reg <= p_reg + 1'b1;
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_COL;
                        end
                    end
                    else
                    begin
                        case (step_reg)
                            2'd0: step_reg <= 2'd3;
                            2'd3:
                            begin
                                prod_reg <= mul_p;
                                step_reg <= 2'd1;
                            end
                            2'd1: step_reg <= 2'd2;
                            default:
                            begin
                                rbuf[CW'(p_reg)] <= diff;
                                any_reg <= any_reg | (diff != 0);
                                p_reg <= p_reg + 1'b1;
                                k_reg <= k_reg + 1'b1;
                                state_reg <= S_COL;
                            end
                        endcase
                    end
                end
                S_NEXT:
                begin
                    if (any_reg)
                        state_reg <= S_OUT;
                    else
                    begin
                        if (phase_reg == 2'd1)
                        begin
                            if (pos_reg == '0)
                                pos_reg <= (RW+1)'(1);
                            else
                                pos_reg <= pos_reg + 1'b1;
                        end
                        else
                            neg_reg <= neg_reg + 1'b1;
                        state_reg <= S_SEEK;
                    end
                end
                S_OUT:
                begin
                    logic [CW:0] oc;
                    oc = (ocol_reg >= ncols - 1'b1) ? ncols - 2'd2 : ocol_reg;
                    result <= '{coeff_out: rbuf[CW'(oc)], row_end: (oc >= ncols - 2'd2),
                                done_res: 1'b0};
                    strobe <= 1'b1;
                    if (oc >= ncols - 2'd2)
                    begin
                        ocol_reg <= '0;
                        if (phase_reg == 2'd1)
                            pos_reg <= pos_reg + 1'b1;
                        else
                            neg_reg <= neg_reg + 1'b1;
                    end
                    else
                        ocol_reg <= oc + 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.op == fmve_pkg::OP_LOAD) |=> !strobe)
        else $error("load produced a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (!result.done_res || (result.coeff_out == 0 && !result.row_end)))
        else $error("done result carries data");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> strobe)
        else $error("row output without strobe");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rows_reg <= RW'(MAX_ROWS)))
        else $error("row count overflow");
endmodule

// ----- src/fmve_gcd.sv -----
// Binary-free Euclid gcd: each remainder step by repeated subtraction of shifted
// divisor, one bit per cycle, then division of both pivots by the gcd, one quotient
// bit per cycle.
module fmve_gcd (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] pa,
    input  logic signed [31:0] pb,
    output logic               busy,
    output logic signed [63:0] qa,
    output logic signed [63:0] qb
);
    typedef enum logic [2:0] {S_IDLE, S_MOD, S_DIVA, S_DIVB, S_FIN} state_t;
    state_t      state_reg;
    logic [32:0] a_reg, b_reg, rem_reg, quo_reg, div_reg;
    logic [5:0]  bit_reg;
    logic [32:0] ua_reg, ub_reg;
    logic        na_reg, nb_reg;
    logic signed [63:0] qa_reg, qb_reg;
    logic [33:0] trial;
    logic [32:0] rem_sh;

    assign busy = (state_reg != S_IDLE);
    assign qa = qa_reg;
    assign qb = qb_reg;
    assign rem_sh = {rem_reg[31:0], quo_reg[32]};
    assign trial = {1'b0, rem_sh} - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ua_reg  <= pa[31] ? 33'(-34'(pa)) : 33'(pa);
                        ub_reg  <= pb[31] ? 33'(-34'(pb)) : 33'(pb);
                        a_reg   <= pa[31] ? 33'(-34'(pa)) : 33'(pa);
                        b_reg   <= pb[31] ? 33'(-34'(pb)) : 33'(pb);
                        na_reg  <= pa[31];
                        nb_reg  <= pb[31];
                        quo_reg <= pa[31] ? 33'(-34'(pa)) : 33'(pa);
                        div_reg <= pb[31] ? 33'(-34'(pb)) : 33'(pb);
                        rem_reg <= '0;
                        bit_reg <= 6'd0;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (b_reg == '0)
                    begin
                        if (a_reg == '0)
                            a_reg <= 33'd1;
                        quo_reg   <= ua_reg;
                        div_reg   <= (a_reg == '0) ? 33'd1 : a_reg;
                        rem_reg   <= '0;
                        bit_reg   <= 6'd0;
                        state_reg <= S_DIVA;
                    end
                    else if (bit_reg == 6'd33)
                    begin
                        a_reg   <= b_reg;
                        b_reg   <= rem_reg;
                        quo_reg <= b_reg;
                        div_reg <= rem_reg;
                        rem_reg <= '0;
                        bit_reg <= 6'd0;
                    end
                    else
                    begin
                        if (!trial[33])
                            rem_reg <= trial[32:0];
                        else
                            rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[31:0], !trial[33]};
                        bit_reg <= bit_reg + 6'd1;
                    end
                end
                S_DIVA, S_DIVB:
                begin
                    if (bit_reg == 6'd33)
                    begin
                        if (state_reg == S_DIVA)
                        begin
                            qa_reg  <= na_reg ? -64'(quo_reg) : 64'(quo_reg);
                            quo_reg <= ub_reg;
                            rem_reg <= '0;
                            bit_reg <= 6'd0;
                            state_reg <= S_DIVB;
                        end
                        else
                        begin
                            qb_reg    <= nb_reg ? -64'(quo_reg) : 64'(quo_reg);
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        if (!trial[33])
                            rem_reg <= trial[32:0];
                        else
                            rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[31:0], !trial[33]};
                        bit_reg <= bit_reg + 6'd1;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> busy)
        else $error("gcd did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (bit_reg <= 6'd33))
        else $error("gcd bit counter overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVB) |-> (div_reg != '0))
        else $error("gcd divide by zero");
endmodule
